// ===== design/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ODTT_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ODTT_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");

`endif

// ===== design/odtt_pkg.sv =====
`default_nettype none

package odtt_pkg;

    localparam int FREQ_W = 14;
    localparam int UTIL_W = 11;
    localparam int TEMP_W = 12;
    localparam int CORE_W = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 14;

    // The scale factor 80/100 reduces to 4/5: the frequency is shifted left
    // by two and divided by five.
    localparam int SCALE_SHIFT = 2;
    localparam int SCALE_DIV = 5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FREQ  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FREQ  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_STEP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_THR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_THR  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CRIT_TEMP = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOV_TEMP = 3'd6;

    // Register values after reset.
    localparam logic [FREQ_W-1:0] RST_MIN_FREQ = 14'd1000;
    localparam logic [FREQ_W-1:0] RST_MAX_FREQ = 14'd4000;
    localparam logic [FREQ_W-1:0] RST_FREQ_STEP = 14'd100;
    localparam logic [UTIL_W-1:0] RST_UP_THR = 11'd717;
    localparam logic [UTIL_W-1:0] RST_DOWN_THR = 11'd307;
    localparam logic signed [TEMP_W-1:0] RST_CRIT_TEMP = 12'sd800;
    localparam logic signed [TEMP_W-1:0] RST_RECOV_TEMP = 12'sd780;

    typedef struct packed {
        logic [CORE_W-1:0]        core_index;
        logic                     core_active;
        logic [FREQ_W-1:0]        current_freq_mhz;
        logic [UTIL_W-1:0]        utilization;
        logic signed [TEMP_W-1:0] peak_temp;
    } req_item_t;

    typedef struct packed {
        logic [CORE_W-1:0] out_core_index;
        logic [FREQ_W-1:0] new_freq_mhz;
        logic              throttled;
    } rsp_item_t;

endpackage

`default_nettype wire

// ===== design/odtt_lower_unit.sv =====
`default_nettype none

// Bit-serial frequency lowering. The dividend 4*f leaves a shift register
// one bit per cycle, most significant first. A divide-by-five stage turns
// each bit into one quotient bit of floor(4f/5), and that quotient bit goes
// straight into a restoring remainder stage modulo the step. After all bits
// have passed, scaled holds floor(4f/5) and remainder holds it modulo step.
module odtt_lower_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [odtt_pkg::FREQ_W-1:0] freq,
    input  wire logic [odtt_pkg::FREQ_W-1:0] step,
    output logic                             done,
    output logic [odtt_pkg::FREQ_W-1:0]      scaled,
    output logic [odtt_pkg::FREQ_W-1:0]      remainder
);
    import odtt_pkg::*;

    localparam int DIV_W = FREQ_W + SCALE_SHIFT;
    localparam int CNT_W = $clog2(DIV_W + 1);
    localparam int R5_W = $clog2(SCALE_DIV);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [DIV_W-1:0]  div_reg;
    logic [R5_W-1:0]   r5_reg;
    logic [FREQ_W-1:0] g_reg;
    logic [FREQ_W-1:0] rem_reg;

    logic [R5_W:0]     r5_ext;
    logic [R5_W:0]     r5_sub;
    logic              qbit;
    logic [FREQ_W:0]   rem_ext;
    logic [FREQ_W:0]   rem_sub;

    always_comb
    begin
        r5_ext = {r5_reg, div_reg[DIV_W-1]};
        qbit = (r5_ext >= (R5_W+1)'(SCALE_DIV));
        r5_sub = qbit ? (r5_ext - (R5_W+1)'(SCALE_DIV)) : r5_ext;
        rem_ext = {rem_reg, qbit};
        rem_sub = (rem_ext >= {1'b0, step}) ? (rem_ext - {1'b0, step}) : rem_ext;
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = CNT_W'(DIV_W);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= {freq, {SCALE_SHIFT{1'b0}}};
            r5_reg <= '0;
            g_reg <= '0;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            div_reg <= {div_reg[DIV_W-2:0], 1'b0};
            r5_reg <= r5_sub[R5_W-1:0];
            g_reg <= {g_reg[FREQ_W-2:0], qbit};
            rem_reg <= rem_sub[FREQ_W-1:0];
        end
    end

    assign done = done_reg;
    assign scaled = g_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== design/ondemand_dvfs_thermal_throttle_unit.sv =====
// Ondemand DVFS governor with thermal throttling. Each request names a core
// and carries its utilization, present frequency, active flag and the chip
// peak temperature; each request yields exactly one response with the new
// frequency and the throttle flag, in request order. The throttle flag sets
// when the peak is above critical_temp, clears when it is below
// recovered_temp, and otherwise holds. A request that keeps, raises or drops
// to the minimum frequency goes straight to the wait state. A request that
// lowers the frequency by 80/100 and floors it to the step first passes the
// sixteen-step bit-serial divider that works out both the scaling and the
// remainder modulo the step. A finished response waits in an output
// register, so a new request can be taken while the previous response is
// still stalled. Configuration writes are always taken and must only be
// issued while no request is in flight.
`default_nettype none

module ondemand_dvfs_thermal_throttle_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            req_valid,
    output logic                                 req_stall,
    input  wire odtt_pkg::req_item_t             req_data,

    output logic                                 rsp_valid,
    input  wire logic                            rsp_stall,
    output odtt_pkg::rsp_item_t                  rsp_data,

    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [odtt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [odtt_pkg::CFG_DATA_W-1:0] cfg_data
);
    import odtt_pkg::*;

    // Request sequencer states.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;
    localparam logic [1:0] ST_WAIT = 2'd3;

    logic [1:0] state_reg, state_next;

    // Configuration registers.
    logic [FREQ_W-1:0]        min_freq_reg;
    logic [FREQ_W-1:0]        max_freq_reg;
    logic [FREQ_W-1:0]        freq_step_reg;
    logic [UTIL_W-1:0]        up_thr_reg;
    logic [UTIL_W-1:0]        down_thr_reg;
    logic signed [TEMP_W-1:0] crit_temp_reg;
    logic signed [TEMP_W-1:0] recov_temp_reg;

    logic throttle_reg, throttle_next;

    // Work registers of the request in flight.
    logic [CORE_W-1:0] core_reg;
    logic [FREQ_W-1:0] res_reg;

    logic      rsp_valid_reg, rsp_valid_next;
    rsp_item_t rsp_data_reg;

    logic                     req_acc;
    logic                     cfg_acc;
    logic                     rsp_load;
    logic signed [TEMP_W-1:0] peak;
    logic                     go_min;
    logic                     go_max;
    logic                     go_lower;
    logic [FREQ_W-1:0]        direct_freq;
    logic [FREQ_W-1:0]        step_eff;

    logic              unit_done;
    logic [FREQ_W-1:0] unit_scaled;
    logic [FREQ_W-1:0] unit_rem;
    logic [FREQ_W-1:0] floored;
    logic [FREQ_W-1:0] lowered;

    assign req_stall = (state_reg != ST_IDLE);
    assign req_acc = req_valid && !req_stall;
    assign cfg_ready = 1'b1;
    assign cfg_acc = cfg_valid && cfg_ready;

    // A zero step behaves as a step of one, so nothing is floored away.
    assign step_eff = (freq_step_reg == '0) ? FREQ_W'(1) : freq_step_reg;

    // Throttle update with hysteresis; the critical limit wins when the limits
    // are inverted.
    always_comb
    begin
        peak = $signed(req_data.peak_temp);
        if (peak > crit_temp_reg)
        begin
            throttle_next = 1'b1;
        end
        else if (peak < recov_temp_reg)
        begin
            throttle_next = 1'b0;
        end
        else
        begin
            throttle_next = throttle_reg;
        end
    end

    // Frequency decision. Lowering is skipped when the core already sits at
    // the minimum; otherwise it goes to the serial unit.
    always_comb
    begin
        go_min = throttle_next || !req_data.core_active;
        go_max = !go_min && (req_data.utilization > up_thr_reg);
        go_lower = !go_min && !go_max && (req_data.utilization < down_thr_reg)
                   && (req_data.current_freq_mhz != min_freq_reg);
        if (go_min)
        begin
            direct_freq = min_freq_reg;
        end
        else if (go_max)
        begin
            direct_freq = max_freq_reg;
        end
        else
        begin
            direct_freq = req_data.current_freq_mhz;
        end
    end

    odtt_lower_unit u_lower (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (req_acc && go_lower),
        .freq      (req_data.current_freq_mhz),
        .step      (step_eff),
        .done      (unit_done),
        .scaled    (unit_scaled),
        .remainder (unit_rem)
    );

    // Floor to the step, then clamp at the minimum.
    assign floored = unit_scaled - unit_rem;
    assign lowered = (floored < min_freq_reg) ? min_freq_reg : floored;

    // The output register loads a waiting response when it is empty or its response leaves now.
    assign rsp_load = (state_reg == ST_WAIT) && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_acc)
                begin
                    state_next = go_lower ? ST_RUN : ST_WAIT;
                end
            end
            ST_RUN:
            begin
                if (unit_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (rsp_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            throttle_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (req_acc)
            begin
                throttle_reg <= throttle_next;
            end
        end
    end

    // Configuration writes; an unknown index is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_freq_reg <= RST_MIN_FREQ;
            max_freq_reg <= RST_MAX_FREQ;
            freq_step_reg <= RST_FREQ_STEP;
            up_thr_reg <= RST_UP_THR;
            down_thr_reg <= RST_DOWN_THR;
            crit_temp_reg <= RST_CRIT_TEMP;
            recov_temp_reg <= RST_RECOV_TEMP;
        end
        else if (cfg_acc)
        begin
            case (cfg_index)
                CFG_MIN_FREQ:   min_freq_reg <= cfg_data[FREQ_W-1:0];
                CFG_MAX_FREQ:   max_freq_reg <= cfg_data[FREQ_W-1:0];
                CFG_FREQ_STEP:  freq_step_reg <= cfg_data[FREQ_W-1:0];
                CFG_UP_THR:     up_thr_reg <= cfg_data[UTIL_W-1:0];
                CFG_DOWN_THR:   down_thr_reg <= cfg_data[UTIL_W-1:0];
                CFG_CRIT_TEMP:  crit_temp_reg <= $signed(cfg_data[TEMP_W-1:0]);
                CFG_RECOV_TEMP: recov_temp_reg <= $signed(cfg_data[TEMP_W-1:0]);
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            core_reg <= req_data.core_index;
            res_reg <= direct_freq;
        end
        else if (state_reg == ST_FIN)
        begin
            res_reg <= lowered;
        end
        if (rsp_load)
        begin
            rsp_data_reg.out_core_index <= core_reg;
            rsp_data_reg.new_freq_mhz <= res_reg;
            rsp_data_reg.throttled <= throttle_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data = rsp_data_reg;

endmodule

`default_nettype wire

// ===== design/odtt_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module odtt_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                req_valid,
    input wire logic                req_stall,
    input wire logic                rsp_valid,
    input wire logic                rsp_stall,
    input wire odtt_pkg::rsp_item_t rsp_data
);
    // A stalled response keeps its payload.
    `ODTT_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, $stable(rsp_data))

    // Once a request is taken, the block is busy for at least the next cycle.
    `ODTT_ASSERT_NXT(a_busy_after_req, clk, rst_n, req_valid && !req_stall, req_stall)

    // A new response only appears while a request was being worked on.
    `ODTT_ASSERT_IMP(a_rsp_from_work, clk, rst_n, $rose(rsp_valid), $past(req_stall))

endmodule

bind ondemand_dvfs_thermal_throttle_unit odtt_checker u_odtt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
);

`default_nettype wire
